// File: rtl/windowed_peak_force_stepper_assert.svh
// Assertion macros shared by the windowed peak force stepper RTL.
// Depends on nothing; the using module provides clk and rst_n.
`ifndef WINDOWED_PEAK_FORCE_STEPPER_ASSERT_SVH
`define WINDOWED_PEAK_FORCE_STEPPER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define WPFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define WPFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/wpfs_pkg.sv
// Types and constants of the windowed peak force stepper.
// No dependencies; used by the lane, merge and top-level files.
package wpfs_pkg;

  localparam int TABLES = 4;

  localparam int PC_W    = 12;
  localparam int FORCE_W = 19;
  localparam int POS_W   = 21;
  localparam int FINE_W  = 20;
  localparam int STEP_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int PROD_W  = 26;  // 19-bit value times 100 or 105

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_FAST_DOWN = 3'd1,
    PH_SLOW_DOWN = 3'd2,
    PH_HOLD      = 3'd3,
    PH_SLOW_UP   = 3'd4,
    PH_FAST_UP   = 3'd5
  } phase_t;

  typedef logic signed [STEP_W-1:0] step_t;

  localparam step_t STEP_FAST_DOWN = -8'sd100;
  localparam step_t STEP_SLOW_DOWN = -8'sd10;
  localparam step_t STEP_NONE      = 8'sd0;
  localparam step_t STEP_SLOW_UP   = 8'sd20;
  localparam step_t STEP_FAST_UP   = 8'sd100;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET0      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET1      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET2      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET3      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FINE_ZONE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT      = 3'd7;

  localparam logic [PC_W-1:0]   WINDOW_START_RST = 12'd3050;
  localparam logic [PC_W-1:0]   WINDOW_END_RST   = 12'd3200;
  localparam logic [FINE_W-1:0] FINE_ZONE_RST    = 20'd2000;

  typedef struct packed {
    logic track;   // running tick inside the window
    logic clear;   // first tick of the window
    logic emit;    // first running tick after the window
  } lane_ctl_t;

  typedef struct packed {
    phase_t phase;
    step_t  step;
  } lane_res_t;

  typedef struct packed {
    lane_res_t [TABLES-1:0] lane;
  } result_t;

endpackage

// File: rtl/wpfs_in_if.sv
// Tick channel of the windowed peak force stepper: valid/ready plus fields.
// Depends on wpfs_pkg for field widths.
interface wpfs_in_if;
  logic                              valid;
  logic                              ready;
  logic [wpfs_pkg::PC_W-1:0]         phase_count;
  logic                              running;
  logic [wpfs_pkg::FORCE_W-1:0]      force_cell0;
  logic [wpfs_pkg::FORCE_W-1:0]      force_cell1;
  logic [wpfs_pkg::FORCE_W-1:0]      force_cell2;
  logic [wpfs_pkg::FORCE_W-1:0]      force_cell3;
  logic signed [wpfs_pkg::POS_W-1:0] pos_table0;
  logic signed [wpfs_pkg::POS_W-1:0] pos_table1;
  logic signed [wpfs_pkg::POS_W-1:0] pos_table2;
  logic signed [wpfs_pkg::POS_W-1:0] pos_table3;

  modport source (output valid, phase_count, running, force_cell0, force_cell1,
                  force_cell2, force_cell3, pos_table0, pos_table1, pos_table2,
                  pos_table3, input ready);
  modport sink (input valid, phase_count, running, force_cell0, force_cell1,
                force_cell2, force_cell3, pos_table0, pos_table1, pos_table2,
                pos_table3, output ready);
endinterface

// File: rtl/wpfs_out_if.sv
// Result channel of the windowed peak force stepper: valid/ready plus fields.
// Depends on wpfs_pkg for field widths.
interface wpfs_out_if;
  logic                               valid;
  logic                               ready;
  logic [2:0]                         phase_table0;
  logic [2:0]                         phase_table1;
  logic [2:0]                         phase_table2;
  logic [2:0]                         phase_table3;
  logic signed [wpfs_pkg::STEP_W-1:0] step_table0;
  logic signed [wpfs_pkg::STEP_W-1:0] step_table1;
  logic signed [wpfs_pkg::STEP_W-1:0] step_table2;
  logic signed [wpfs_pkg::STEP_W-1:0] step_table3;

  modport source (output valid, phase_table0, phase_table1, phase_table2,
                  phase_table3, step_table0, step_table1, step_table2,
                  step_table3, input ready);
  modport sink (input valid, phase_table0, phase_table1, phase_table2,
                phase_table3, step_table0, step_table1, step_table2,
                step_table3, output ready);
endinterface

// File: rtl/wpfs_lane.sv
// One table lane: peak force tracker and phase/step decision.
// Depends on wpfs_pkg.
module wpfs_lane (
  input  logic                              clk,
  input  logic                              rst_n,
  input  wpfs_pkg::lane_ctl_t               ctl,
  input  logic [wpfs_pkg::FORCE_W-1:0]      force_in,
  input  logic signed [wpfs_pkg::POS_W-1:0] pos,
  input  logic [wpfs_pkg::FORCE_W-1:0]      target,
  input  logic [wpfs_pkg::FINE_W-1:0]       fine_zone,
  input  logic                              present,
  output wpfs_pkg::lane_res_t               res
);

  logic [wpfs_pkg::FORCE_W-1:0]     peak_r, peak_nxt;
  wpfs_pkg::phase_t                 phase_r, phase_nxt;
  logic signed [wpfs_pkg::FORCE_W:0] err;
  logic [wpfs_pkg::PROD_W-1:0]      peak_x100, target_x105;
  logic                             pos_high;
  wpfs_pkg::phase_t                 dec_phase;
  wpfs_pkg::step_t                  dec_step;

  // peak: restart from the sample on window entry, else running max
  always_comb begin
    peak_nxt = peak_r;
    if (ctl.track) begin
      if (ctl.clear || force_in > peak_r) begin
        peak_nxt = force_in;
      end
    end
  end

  assign err = $signed({1'b0, target}) - $signed({1'b0, peak_r});
  assign peak_x100   = wpfs_pkg::PROD_W'(peak_r) * wpfs_pkg::PROD_W'(100);
  assign target_x105 = wpfs_pkg::PROD_W'(target) * wpfs_pkg::PROD_W'(105);
  assign pos_high = pos > $signed({1'b0, fine_zone});

  always_comb begin
    if (err > 2'sd1) begin
      dec_phase = pos_high ? wpfs_pkg::PH_FAST_DOWN : wpfs_pkg::PH_SLOW_DOWN;
      dec_step  = pos_high ? wpfs_pkg::STEP_FAST_DOWN : wpfs_pkg::STEP_SLOW_DOWN;
    end else if (err == '0) begin
      dec_phase = wpfs_pkg::PH_HOLD;
      dec_step  = wpfs_pkg::STEP_NONE;
    end else if (err < -2'sd1) begin
      dec_phase = (peak_x100 > target_x105) ? wpfs_pkg::PH_FAST_UP : wpfs_pkg::PH_SLOW_UP;
      dec_step  = (peak_x100 > target_x105) ? wpfs_pkg::STEP_FAST_UP : wpfs_pkg::STEP_SLOW_UP;
    end else begin
      // inside the deadband but not on target
      dec_phase = wpfs_pkg::PH_IDLE;
      dec_step  = wpfs_pkg::STEP_NONE;
    end
  end

  assign phase_nxt = (ctl.emit && present) ? dec_phase : phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r  <= '0;
      phase_r <= wpfs_pkg::PH_IDLE;
    end else begin
      peak_r  <= peak_nxt;
      phase_r <= phase_nxt;
    end
  end

  // absent table shows its last phase and no move
  assign res.phase = present ? dec_phase : phase_r;
  assign res.step  = present ? dec_step : wpfs_pkg::STEP_NONE;

endmodule

// File: rtl/wpfs_merge.sv
// Merge stage: gathers lane results into one item, two-entry output buffer.
// Depends on wpfs_pkg, wpfs_out_if and the assertion macro header.
`include "windowed_peak_force_stepper_assert.svh"

module wpfs_merge (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wpfs_pkg::result_t res,
  output logic              in_ready,
  wpfs_out_if.source        out_ch
);

  wpfs_pkg::result_t out_data_r, out_data_nxt;
  wpfs_pkg::result_t skid_data_r, skid_data_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  logic              pop;

  assign pop      = out_valid_r && out_ch.ready;
  assign in_ready = !skid_valid_r;

  always_comb begin
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_nxt  = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.phase_table0 = out_data_r.lane[0].phase;
  assign out_ch.phase_table1 = out_data_r.lane[1].phase;
  assign out_ch.phase_table2 = out_data_r.lane[2].phase;
  assign out_ch.phase_table3 = out_data_r.lane[3].phase;
  assign out_ch.step_table0  = out_data_r.lane[0].step;
  assign out_ch.step_table1  = out_data_r.lane[1].step;
  assign out_ch.step_table2  = out_data_r.lane[2].step;
  assign out_ch.step_table3  = out_data_r.lane[3].step;

  `WPFS_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full with output empty")
  `WPFS_ASSERT_NOW(a_no_push_when_full, push, !skid_valid_r, "result pushed into full buffer")
  `WPFS_ASSERT_NEXT(a_stall_fills_skid, push && out_valid_r && !out_ch.ready, skid_valid_r, "stalled result lost")

endmodule

// File: rtl/windowed_peak_force_stepper.sv
// Windowed peak force stepper. The result of a window is registered in the output
// buffer on the transfer of the first running tick past the window.
// Throughput: one tick per cycle; a two-entry output buffer lets ticks keep
// flowing while one result waits, and in_ch.ready drops only when both are full.
// Reset (rst_n, synchronous): config to defaults, window flag, peaks and table
// phases to zero, output buffer empty.
`include "windowed_peak_force_stepper_assert.svh"

module windowed_peak_force_stepper #(
  parameter int NUM_CELLS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  wpfs_in_if.sink                             in_ch,
  wpfs_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [wpfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wpfs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // cells beyond the table count are never used
  localparam int USED_CELLS = (NUM_CELLS < wpfs_pkg::TABLES) ? NUM_CELLS
                                                             : wpfs_pkg::TABLES;

  // configuration registers
  logic [wpfs_pkg::PC_W-1:0]    win_start_r;
  logic [wpfs_pkg::PC_W-1:0]    win_end_r;
  logic [wpfs_pkg::FORCE_W-1:0] target_r [wpfs_pkg::TABLES];
  logic [wpfs_pkg::FINE_W-1:0]  fine_zone_r;
  logic [wpfs_pkg::TABLES-1:0]  present_r;
  logic [1:0]                   tgt_sel;

  // tick control
  logic                 in_ready;
  logic                 in_fire;
  logic                 tick;
  logic                 in_win;
  logic                 was_in_window_r, was_in_window_nxt;
  wpfs_pkg::lane_ctl_t  ctl;
  wpfs_pkg::result_t    res;

  logic [wpfs_pkg::FORCE_W-1:0]      force_v [wpfs_pkg::TABLES];
  logic signed [wpfs_pkg::POS_W-1:0] pos_v   [wpfs_pkg::TABLES];

  assign force_v[0] = in_ch.force_cell0;
  assign force_v[1] = in_ch.force_cell1;
  assign force_v[2] = in_ch.force_cell2;
  assign force_v[3] = in_ch.force_cell3;
  assign pos_v[0]   = in_ch.pos_table0;
  assign pos_v[1]   = in_ch.pos_table1;
  assign pos_v[2]   = in_ch.pos_table2;
  assign pos_v[3]   = in_ch.pos_table3;

  //--------------------------------------------------------------------------
  // Config writes; the user must make them only while the block is quiet (not enforced here).
  //--------------------------------------------------------------------------
  assign tgt_sel = 2'(cfg_index - wpfs_pkg::CFG_TARGET0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r <= wpfs_pkg::WINDOW_START_RST;
      win_end_r   <= wpfs_pkg::WINDOW_END_RST;
      for (int i = 0; i < wpfs_pkg::TABLES; i++) begin
        target_r[i] <= '0;
      end
      fine_zone_r <= wpfs_pkg::FINE_ZONE_RST;
      present_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        wpfs_pkg::CFG_WINDOW_START: win_start_r <= cfg_wdata[wpfs_pkg::PC_W-1:0];
        wpfs_pkg::CFG_WINDOW_END:   win_end_r   <= cfg_wdata[wpfs_pkg::PC_W-1:0];
        wpfs_pkg::CFG_TARGET0, wpfs_pkg::CFG_TARGET1,
        wpfs_pkg::CFG_TARGET2, wpfs_pkg::CFG_TARGET3:
          target_r[tgt_sel] <= cfg_wdata[wpfs_pkg::FORCE_W-1:0];
        wpfs_pkg::CFG_FINE_ZONE:    fine_zone_r <= cfg_wdata[wpfs_pkg::FINE_W-1:0];
        wpfs_pkg::CFG_PRESENT:      present_r   <= cfg_wdata[wpfs_pkg::TABLES-1:0];
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Window tracking. A window with start above end wraps past the top count.
  // Ticks with running low are taken but change nothing.
  //--------------------------------------------------------------------------
  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;
  assign tick        = in_fire && in_ch.running;

  always_comb begin
    if (win_start_r <= win_end_r) begin
      in_win = (in_ch.phase_count >= win_start_r) && (in_ch.phase_count <= win_end_r);
    end else begin
      in_win = (in_ch.phase_count >= win_start_r) || (in_ch.phase_count <= win_end_r);
    end
  end

  assign ctl.track = tick && in_win;
  assign ctl.clear = !was_in_window_r;
  assign ctl.emit  = tick && !in_win && was_in_window_r;

  assign was_in_window_nxt = tick ? in_win : was_in_window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_in_window_r <= 1'b0;
    end else begin
      was_in_window_r <= was_in_window_nxt;
    end
  end

  //--------------------------------------------------------------------------
  // Lanes: one per used cell, all in parallel. Unused tables stay idle.
  //--------------------------------------------------------------------------
  for (genvar g = 0; g < wpfs_pkg::TABLES; g++) begin : g_lane
    if (g < USED_CELLS) begin : g_used
      wpfs_lane u_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .force_in  (force_v[g]),
        .pos       (pos_v[g]),
        .target    (target_r[g]),
        .fine_zone (fine_zone_r),
        .present   (present_r[g]),
        .res       (res.lane[g])
      );
    end else begin : g_unused
      assign res.lane[g].phase = wpfs_pkg::PH_IDLE;
      assign res.lane[g].step  = wpfs_pkg::STEP_NONE;
    end
  end

  //--------------------------------------------------------------------------
  // Merge and output buffer
  //--------------------------------------------------------------------------
  wpfs_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (ctl.emit),
    .res      (res),
    .in_ready (in_ready),
    .out_ch   (out_ch)
  );

  `WPFS_ASSERT_NOW(a_emit_needs_window, ctl.emit, was_in_window_r, "result without a window")
  `WPFS_ASSERT_NEXT(a_track_sets_flag, ctl.track, was_in_window_r, "window flag not set")
  `WPFS_ASSERT_NEXT(a_emit_clears_flag, ctl.emit, !was_in_window_r, "window flag kept after result")

endmodule
